[src/time_window_sum_min_max_defines.svh]
// assertion macros shared by the sliding window statistics block
`ifndef TIME_WINDOW_SUM_MIN_MAX_DEFINES_SVH
`define TIME_WINDOW_SUM_MIN_MAX_DEFINES_SVH

// condition that must hold at every clock edge outside reset
`define TWSMM_CHECK(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// implication checked at every clock edge outside reset
`define TWSMM_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[src/twsmm_pkg.sv]
// package with types and constants of the sliding window statistics block
`timescale 1ns / 1ps

package twsmm_pkg;

	localparam int unsigned RING_DEPTH_DEF = 1024;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned WLEN_W  = 8;
	localparam int unsigned COUNT_W = 11;
	localparam int unsigned SUM_W   = 42;

	localparam logic [WLEN_W-1:0] WLEN_RESET = 8'd60;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OVF_RD,
		ST_OVF_DROP,
		ST_WRITE,
		ST_EV_RD,
		ST_EV_CHK,
		ST_SCAN_INIT,
		ST_SCAN,
		ST_FIN
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_in;
		logic rd_oldest;
		logic drop;
		logic set_ovf;
		logic write;
		logic scan_init;
		logic scan_issue;
		logic out_load;
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic full;
		logic count_gt1;
		logic keep;
		logic stale;
		logic scan_done;
		logic out_free;
	} stat_t;

endpackage

[src/twsmm_ctrl.sv]
// controller state machine sequencing append, eviction, rescan and result
`timescale 1ns / 1ps

module twsmm_ctrl import twsmm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = stat.full ? ST_OVF_RD : ST_WRITE;
				end
			end
			ST_OVF_RD:    state_d = ST_OVF_DROP;
			ST_OVF_DROP:  state_d = ST_WRITE;
			ST_WRITE:     state_d = ST_EV_CHK;
			ST_EV_RD:     state_d = ST_EV_CHK;
			ST_EV_CHK: begin
				if (!stat.count_gt1 || stat.keep) begin
					state_d = stat.stale ? ST_SCAN_INIT : ST_FIN;
				end else begin
					state_d = ST_EV_RD;
				end
			end
			ST_SCAN_INIT: state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_OVF_RD: begin
				cmd.rd_oldest = 1'b1;
			end
			ST_OVF_DROP: begin
				cmd.drop    = 1'b1;
				cmd.set_ovf = 1'b1;
			end
			ST_WRITE: begin
				// the oldest entry is read ahead for the first eviction test
				cmd.write     = 1'b1;
				cmd.rd_oldest = 1'b1;
			end
			ST_EV_RD: begin
				cmd.rd_oldest = 1'b1;
			end
			ST_EV_CHK: begin
				cmd.drop = stat.count_gt1 && !stat.keep;
			end
			ST_SCAN_INIT: begin
				cmd.scan_init = 1'b1;
			end
			ST_SCAN: begin
				cmd.scan_issue = !stat.scan_done;
			end
			ST_FIN: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[src/twsmm_dp.sv]
// datapath with the sample ring, running sum, extrema and result register
`timescale 1ns / 1ps

`include "time_window_sum_min_max_defines.svh"

module twsmm_dp import twsmm_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [WLEN_W-1:0]  cfg_data,
	input  logic [TIME_W-1:0]  in_time,
	input  logic [VALUE_W-1:0] in_value,
	input  logic               m_tready,
	input  cmd_t               cmd,
	output stat_t              stat,
	output logic               out_valid,
	output logic [COUNT_W-1:0] out_count,
	output logic [SUM_W-1:0]   out_sum,
	output logic [VALUE_W-1:0] out_min,
	output logic [VALUE_W-1:0] out_max,
	output logic               out_ovf
);

	localparam int unsigned IDX_W = $clog2(RING_DEPTH);
	localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
	localparam logic [IDX_W:0]   DEPTH_X = (IDX_W + 1)'(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

	logic [TIME_W+VALUE_W-1:0] mem [RING_DEPTH];
	logic [TIME_W+VALUE_W-1:0] rdata_q;

	logic [WLEN_W-1:0]  wlen_q;
	logic [TIME_W-1:0]  t_q;
	logic [VALUE_W-1:0] v_q;
	logic [IDX_W-1:0]   oldest_q;
	logic [CNT_W-1:0]   count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [VALUE_W-1:0] min_q;
	logic [VALUE_W-1:0] max_q;
	logic               stale_q;
	logic               ovf_q;
	logic [IDX_W-1:0]   scan_ptr_q;
	logic [CNT_W-1:0]   scan_left_q;
	logic               scan_vld_s1;
	logic               out_valid_q;

	logic [IDX_W:0]     slot_sum;
	logic [IDX_W-1:0]   wr_addr;
	logic [IDX_W-1:0]   rd_addr;
	logic [VALUE_W-1:0] rd_value;
	logic [TIME_W-1:0]  rd_time;
	logic               rd_en;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	// slot behind the newest entry, oldest plus count folded into the ring
	assign slot_sum = {1'b0, oldest_q} + (IDX_W + 1)'(count_q);
	assign wr_addr  = IDX_W'((slot_sum >= DEPTH_X) ? slot_sum - DEPTH_X : slot_sum);
	assign rd_addr  = cmd.scan_issue ? scan_ptr_q : oldest_q;
	assign rd_en    = cmd.rd_oldest | cmd.scan_issue;
	assign rd_value = rdata_q[VALUE_W-1:0];
	assign rd_time  = rdata_q[TIME_W+VALUE_W-1:VALUE_W];

	always_ff @(posedge clk) begin
		if (cmd.write) begin
			mem[wr_addr] <= {t_q, v_q};
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			t_q <= in_time;
			v_q <= in_value;
		end
		if (cmd.out_load) begin
			out_count <= COUNT_W'(count_q);
			out_sum   <= sum_q;
			out_min   <= min_q;
			out_max   <= max_q;
			out_ovf   <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q      <= WLEN_RESET;
			oldest_q    <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			min_q       <= '1;
			max_q       <= '0;
			stale_q     <= 1'b0;
			ovf_q       <= 1'b0;
			scan_ptr_q  <= '0;
			scan_left_q <= '0;
			scan_vld_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				wlen_q <= cfg_data;
			end
			if (cmd.load_in) begin
				stale_q <= 1'b0;
				ovf_q   <= 1'b0;
			end
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.drop) begin
				sum_q    <= sum_q - SUM_W'(rd_value);
				oldest_q <= idx_inc(oldest_q);
				count_q  <= count_q - 1'b1;
				if (rd_value == min_q || rd_value == max_q) begin
					stale_q <= 1'b1;
				end
			end
			if (cmd.write) begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + SUM_W'(v_q);
				if (v_q < min_q) begin
					min_q <= v_q;
				end
				if (v_q > max_q) begin
					max_q <= v_q;
				end
			end
			if (cmd.scan_init) begin
				min_q       <= '1;
				max_q       <= '0;
				scan_ptr_q  <= oldest_q;
				scan_left_q <= count_q;
			end
			if (cmd.scan_issue) begin
				scan_ptr_q  <= idx_inc(scan_ptr_q);
				scan_left_q <= scan_left_q - 1'b1;
			end
			scan_vld_s1 <= cmd.scan_issue;
			// fold each scanned value in the cycle after its read
			if (scan_vld_s1) begin
				if (rd_value < min_q) begin
					min_q <= rd_value;
				end
				if (rd_value > max_q) begin
					max_q <= rd_value;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.full      = (count_q == DEPTH_C);
		stat.count_gt1 = (count_q > CNT_W'(1));
		stat.keep      = ({1'b0, rd_time} + (TIME_W + 1)'(wlen_q)) >= {1'b0, t_q};
		stat.stale     = stale_q;
		stat.scan_done = (scan_left_q == '0);
		stat.out_free  = !out_valid_q || m_tready;
	end

	assign out_valid = out_valid_q;

	`TWSMM_CHECK(a_count_bound, count_q <= DEPTH_C, "entry count beyond ring depth")
	`TWSMM_IMPLY(a_write_room, cmd.write, count_q < DEPTH_C, "append into a full ring")
	`TWSMM_IMPLY(a_out_free, cmd.out_load, !out_valid_q || m_tready, "result overwritten")
	`TWSMM_IMPLY(a_drop_keeps_one, cmd.drop, count_q != '0, "drop from an empty ring")

endmodule

[src/time_window_sum_min_max.sv]
// top level of the sliding time window count, sum, min and max block
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// s_*       in   s_tvalid / s_tready    timestamp, sample_value
// m_*       out  m_tvalid / m_tready    count, sum, min, max, overflow
// cfg_*     in   cfg_valid / cfg_ready  window_length
//
// an item goes through accept, append, eviction test and result when nothing leaves
// each evicted entry adds a read of the oldest slot, then its test
// a full ring adds a read and a forced drop of the oldest entry
// a rescan after an extremum leaves adds a setup, one read per entry and a last fold
// reset is asynchronous and needs no clearing pass; ring data is only used where written
// a result waits in the output register; the next item is taken while it waits

module time_window_sum_min_max import twsmm_pkg::*; #(
	parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// input transaction
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [63:0]        s_tdata,   // timestamp[31:0], sample_value[63:32]
	// result transaction
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [119:0]       m_tdata,   // window_count[10:0], window_sum[52:11],
	                                      // window_min[84:53], window_max[116:85],
	                                      // overflow[117], zero[119:118]
	// window length write
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [WLEN_W-1:0]  cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	logic [COUNT_W-1:0] window_count;
	logic [SUM_W-1:0]   window_sum;
	logic [VALUE_W-1:0] window_min;
	logic [VALUE_W-1:0] window_max;
	logic               overflow;

	// configuration is always taken; it is to be written only while the block is idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	twsmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	twsmm_dp #(
		.RING_DEPTH (RING_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_time   (s_tdata[31:0]),
		.in_value  (s_tdata[63:32]),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (m_tvalid),
		.out_count (window_count),
		.out_sum   (window_sum),
		.out_min   (window_min),
		.out_max   (window_max),
		.out_ovf   (overflow)
	);

	// result fields packed from the lowest bit up, padded to whole bytes
	assign m_tdata = {2'b00, overflow, window_max, window_min, window_sum, window_count};

endmodule

[verif/tb_time_window_sum_min_max.sv]
// self-checking testbench for the sliding time window count, sum, min and max block
`timescale 1ns / 1ps

module tb_time_window_sum_min_max;
	import twsmm_pkg::*;

	localparam int unsigned DEPTH       = RING_DEPTH_DEF;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_SLACK = 64;

	// one result transaction, fields from the lowest bit up as on m_tdata
	typedef struct packed {
		logic               ovf;
		logic [VALUE_W-1:0] vmax;
		logic [VALUE_W-1:0] vmin;
		logic [SUM_W-1:0]   sum;
		logic [COUNT_W-1:0] count;
	} window_stats_t;

	// ways the result side takes transactions
	typedef enum int {
		RX_FREE,
		RX_COIN,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	// own copy of the window state, predicts one result per accepted sample
	class window_stats_board;
		logic [TIME_W-1:0]  slot_time [DEPTH];
		logic [VALUE_W-1:0] slot_value [DEPTH];
		int unsigned        head;
		int unsigned        fill;
		logic [SUM_W-1:0]   total;
		logic [VALUE_W-1:0] lo;
		logic [VALUE_W-1:0] hi;
		logic [WLEN_W-1:0]  wlen;
		window_stats_t      expected_stats [$];
		int unsigned        samples_in;
		int unsigned        results_out;
		int unsigned        overflows;
		int unsigned        rescans;
		int unsigned        mismatches;

		function new();
			head        = 0;
			fill        = 0;
			total       = '0;
			lo          = '1;
			hi          = '0;
			wlen        = WLEN_RESET;
			samples_in  = 0;
			results_out = 0;
			overflows   = 0;
			rescans     = 0;
			mismatches  = 0;
		endfunction

		function void set_window(logic [WLEN_W-1:0] w);
			wlen = w;
		endfunction

		// retire the oldest entry, tell whether it held the min or the max
		function bit retire_oldest();
			logic [VALUE_W-1:0] v;
			v     = slot_value[head];
			total = total - SUM_W'(v);
			head  = (head + 1) % DEPTH;
			fill--;
			return (v == lo) || (v == hi);
		endfunction

		function void note_sample(logic [TIME_W-1:0] t, logic [VALUE_W-1:0] v);
			window_stats_t e;
			bit            stale;
			logic [TIME_W:0] reach;
			int unsigned   k;
			int unsigned   slot;
			stale = 1'b0;
			e.ovf = 1'b0;
			samples_in++;
			// ring full: the oldest entry is forced out first
			if (fill >= DEPTH) begin
				e.ovf = 1'b1;
				overflows++;
				if (retire_oldest())
					stale = 1'b1;
			end
			slot             = (head + fill) % DEPTH;
			slot_time[slot]  = t;
			slot_value[slot] = v;
			fill++;
			total = total + SUM_W'(v);
			if (v < lo)
				lo = v;
			if (v > hi)
				hi = v;
			// only the oldest entry is tested, a late one blocks those behind it
			while (fill > 1) begin
				reach = {1'b0, slot_time[head]};
				reach = reach + (TIME_W + 1)'(wlen);
				if (reach >= {1'b0, t})
					break;
				if (retire_oldest())
					stale = 1'b1;
			end
			if (stale) begin
				rescans++;
				lo = '1;
				hi = '0;
				for (k = 0; k < fill; k++) begin
					slot = (head + k) % DEPTH;
					if (slot_value[slot] < lo)
						lo = slot_value[slot];
					if (slot_value[slot] > hi)
						hi = slot_value[slot];
				end
			end
			e.count = COUNT_W'(fill);
			e.sum   = total;
			e.vmin  = lo;
			e.vmax  = hi;
			expected_stats = {expected_stats, e};
		endfunction

		task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at %0t ns, result %0d: %s expected %0h got %0h",
					$time, results_out, what, want, got);
		endtask

		task check_result(logic [119:0] word);
			window_stats_t got;
			window_stats_t want;
			got = word[117:0];
			results_out++;
			if (expected_stats.size() == 0) begin
				report_mismatch("result with nothing pending, count", '0, 64'(got.count));
				return;
			end
			want = expected_stats[0];
			expected_stats.delete(0);
			if (got.count != want.count)
				report_mismatch("window_count", 64'(want.count), 64'(got.count));
			if (got.sum != want.sum)
				report_mismatch("window_sum", 64'(want.sum), 64'(got.sum));
			if (got.vmin != want.vmin)
				report_mismatch("window_min", 64'(want.vmin), 64'(got.vmin));
			if (got.vmax != want.vmax)
				report_mismatch("window_max", 64'(want.vmax), 64'(got.vmax));
			if (got.ovf != want.ovf)
				report_mismatch("overflow", 64'(want.ovf), 64'(got.ovf));
			if (word[119:118] != 2'b00)
				report_mismatch("padding bits", '0, 64'(word[119:118]));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [63:0]        s_tdata;   // timestamp[31:0], sample_value[63:32]
	logic               m_tvalid;
	logic               m_tready;
	logic [119:0]       m_tdata;   // window_count[10:0], window_sum[52:11],
	                               // window_min[84:53], window_max[116:85],
	                               // overflow[117], zero[119:118]
	logic               cfg_valid;
	logic               cfg_ready;
	logic [WLEN_W-1:0]  cfg_data;

	window_stats_board board;
	int unsigned       burst_left;
	int unsigned       windows_set;
	bit                hold_request;

	time_window_sum_min_max uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// every accepted result transaction goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	// offer one sample, bursts of random length with idle gaps between them
	task automatic push_sample(logic [TIME_W-1:0] t, logic [VALUE_W-1:0] v);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
		end
		s_tdata  = {v, t};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		board.note_sample(t, v);
		burst_left--;
		@(negedge clk);
	endtask

	// window length write, only while nothing is in flight
	task automatic write_window(logic [WLEN_W-1:0] w);
		cfg_data  = w;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		board.set_window(w);
		windows_set++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// stop offering and wait for every pending result
	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (board.expected_stats.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// mostly rising times with steps scaled to the window, some late and some far samples
	task automatic random_phase(int unsigned n, logic [TIME_W-1:0] start, bit with_pressure);
		logic [TIME_W-1:0]  t;
		logic [VALUE_W-1:0] v;
		logic [TIME_W:0]    ahead;
		int unsigned        step_max;
		int unsigned        pick;
		int unsigned        i;
		t        = start;
		step_max = 32'(board.wlen) / 16 + 1;
		for (i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 6 && t >= 40) begin
				t = t - $urandom_range(1, 40);
			end else begin
				if (pick < 10)
					ahead = {1'b0, t} + (TIME_W + 1)'(board.wlen)
						+ (TIME_W + 1)'($urandom_range(1, 500));
				else
					ahead = {1'b0, t} + (TIME_W + 1)'($urandom_range(0, step_max));
				// times saturate at the top instead of wrapping
				t = ahead[TIME_W] ? '1 : ahead[TIME_W-1:0];
			end
			case ($urandom_range(0, 9))
				0: v = '0;
				1: v = '1;
				2, 3: v = $urandom_range(0, 15);
				default: v = $urandom;
			endcase
			if (with_pressure && i == n / 4)
				hold_request = 1'b1;
			if (with_pressure && i == n / 2)
				wait_drained();
			push_sample(t, v);
		end
	endtask

	// one time for all samples so the ring fills and overflows
	task automatic overflow_phase(int unsigned n);
		logic [TIME_W-1:0]  t;
		logic [VALUE_W-1:0] v;
		int unsigned        i;
		t = $urandom;
		if (t > 32'hFFFF_0000)
			t = 32'hFFFF_0000;
		for (i = 0; i < n; i++) begin
			// extremes first so the forced drops have to rescan
			case (i)
				0: v = '0;
				1: v = '1;
				2: v = 32'd1;
				3: v = 32'hFFFF_FFFE;
				default: v = $urandom_range(2, 32'hFFFF_FFFD);
			endcase
			push_sample(t, v);
		end
		// everything ages out at once
		push_sample(t + 300, $urandom);
	endtask

	// receiver: own stall pattern, plus one long hold on request
	initial begin
		rx_mode_t    mode;
		int unsigned left;
		logic [11:0] pattern;
		m_tready = 1'b0;
		mode     = RX_FREE;
		left     = 0;
		pattern  = 12'b1011_0011_1001;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(16, 96);
				end
				left--;
				case (mode)
					RX_FREE:    m_tready = 1'b1;
					RX_COIN:    m_tready = 1'($urandom_range(0, 1));
					RX_PATTERN: begin
						m_tready = pattern[0];
						pattern  = {pattern[0], pattern[11:1]};
					end
					default:    m_tready = ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// stimulus and end of run
	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		hold_request = 1'b0;
		burst_left   = 0;
		windows_set  = 0;
		board        = new();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset window length: zero and full-scale values, then both extremes leave
		push_sample(32'd0, 32'd0);
		push_sample(32'd0, '1);
		push_sample(32'd10, 32'd5);
		push_sample(32'd60, 32'd7);
		push_sample(32'd61, 32'd3);
		// late sample, nothing leaves
		push_sample(32'd50, 32'd100);
		// far jump clears all but the new one
		push_sample(32'd200, 32'd9);
		wait_drained();

		// zero length: only the newest time stays, ties on min and max
		write_window(8'd0);
		push_sample(32'd300, 32'd4);
		push_sample(32'd300, 32'd4);
		push_sample(32'd300, 32'd9);
		push_sample(32'd301, 32'd6);
		push_sample(32'd301, 32'd6);
		wait_drained();

		// full length: kept at the exact edge, gone one unit later
		write_window(8'd255);
		push_sample(32'd1000, 32'd8);
		push_sample(32'd1255, 32'd2);
		push_sample(32'd1256, 32'd1);
		wait_drained();

		// random content, long receiver hold and a mid-phase pause
		random_phase(150, $urandom_range(0, 32'hF000_0000), 1'b1);
		wait_drained();
		write_window(8'd0);
		random_phase(100, $urandom_range(0, 32'hF000_0000), 1'b0);
		wait_drained();
		write_window(8'd1);
		random_phase(80, $urandom_range(0, 32'hF000_0000), 1'b0);
		wait_drained();
		write_window(WLEN_W'($urandom_range(2, 254)));
		random_phase(60, $urandom_range(0, 32'hF000_0000), 1'b0);
		wait_drained();

		// times near the top saturate, those entries then never age out
		write_window(WLEN_W'($urandom_range(2, 254)));
		random_phase(80, 32'hFFFF_FFFF - $urandom_range(0, 2000), 1'b0);
		push_sample('1, 32'd1);
		push_sample('1, '1);
		// late samples behind a blocking entry
		push_sample(32'd0, 32'd2);
		push_sample(32'd5, 32'd0);
		wait_drained();

		// ring fill, forced drops and a full clear
		write_window(WLEN_W'($urandom_range(2, 254)));
		overflow_phase(1060);
		wait_drained();

		write_window(WLEN_RESET);
		random_phase(100, $urandom_range(0, 32'hF000_0000), 1'b0);
		wait_drained();
		repeat (DRAIN_SLACK) @(negedge clk);

		if (board.expected_stats.size() != 0)
			board.report_mismatch("results never arrived",
				64'(board.expected_stats.size()), '0);
		$display("run: %0d samples, %0d results, %0d window length writes",
			board.samples_in, board.results_out, windows_set);
		$display("run: %0d results with the ring full, %0d min/max rescans",
			board.overflows, board.rescans);
		if (board.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#100_000_000;
		$display("timeout at %0t ns", $time);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
